@@ src/gtca_pkg.sv @@
package gtca_pkg;

    localparam int SLOTS   = 3;
    localparam int NUM_ENT = SLOTS * SLOTS;
    localparam int COORD_W = 16;
    localparam int ABS_W   = COORD_W;
    localparam int SQ_W    = 2 * ABS_W;
    localparam int DIST_W  = SQ_W + 1;
    localparam int IDX_W   = 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [ABS_W-1:0]          absd_t;
    typedef logic [SQ_W-1:0]           sq_t;
    typedef logic [DIST_W-1:0]         dist_t;
    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [NUM_ENT-1:0]        ent_mask_t;

    typedef struct packed {
        coord_t track0_x;
        coord_t track0_y;
        coord_t track1_x;
        coord_t track1_y;
        coord_t track2_x;
        coord_t track2_y;
        coord_t cluster0_x;
        coord_t cluster0_y;
        coord_t cluster1_x;
        coord_t cluster1_y;
        coord_t cluster2_x;
        coord_t cluster2_y;
    } item_t;

    typedef struct packed {
        idx_t track0_cluster;
        idx_t track1_cluster;
        idx_t track2_cluster;
    } result_t;

    // Entries (row, col) with row and col below n take part.
    function automatic ent_mask_t active_mask(input int n);
        ent_mask_t m;
        int        k;
        for (k = 0; k < NUM_ENT; k++)
        begin
            m[k] = ((k / SLOTS) < n) && ((k % SLOTS) < n);
        end
        return m;
    endfunction

    // All entries that share a row or a column with entry k.
    function automatic ent_mask_t line_mask(input int k);
        ent_mask_t m;
        int        q;
        for (q = 0; q < NUM_ENT; q++)
        begin
            m[q] = ((q / SLOTS) == (k / SLOTS)) || ((q % SLOTS) == (k % SLOTS));
        end
        return m;
    endfunction

    // One-hot pick of the smallest masked entry; earliest in row-major order wins ties.
    // All pairwise compares run in parallel.
    function automatic ent_mask_t pick_first_min(input dist_t [NUM_ENT-1:0] d,
                                                 input ent_mask_t m);
        ent_mask_t w;
        int        k;
        int        q;
        for (k = 0; k < NUM_ENT; k++)
        begin
            w[k] = m[k];
            for (q = 0; q < NUM_ENT; q++)
            begin
                if (m[q] && (q < k))
                begin
                    w[k] = w[k] && (d[k] < d[q]);
                end
                else if (m[q] && (q > k))
                begin
                    w[k] = w[k] && (d[k] <= d[q]);
                end
            end
        end
        return w;
    endfunction

    // Retire every row and column that holds a picked entry.
    function automatic ent_mask_t retire(input ent_mask_t m, input ent_mask_t picked);
        ent_mask_t r;
        int        k;
        r = m;
        for (k = 0; k < NUM_ENT; k++)
        begin
            if (picked[k])
            begin
                r = r & ~line_mask(k);
            end
        end
        return r;
    endfunction

endpackage

@@ src/greedy_track_cluster_assign.sv @@
// Greedy track-to-cluster assignment for three tracks and three cluster centroids.
// Each beat on the item channel carries predicted x/y of three tracks and x/y of three
// cluster centroids (signed 16-bit mm); each beat on the result channel gives the cluster
// index chosen for each track. The block forms the nine squared distances exactly, then
// picks greedily: the smallest free distance first (ties go to the earliest entry in
// track-major order), retiring that track and that cluster, and so on. With NUM_TRACKS = 2
// only tracks 0..1 and clusters 0..1 take part and track2_cluster reads 0. The datapath is
// a six-stage pipeline (input register, absolute differences, squares, distance sums,
// first pick, remaining picks into the output register). An item passes through these
// registers in order before result_valid rises; with result_ready held high, one item is
// taken every cycle. Each stage holds its beat only while it is full and the stage behind
// it is stalled, so a result waiting on result_ready does not stop items from filling
// empty stages.
module greedy_track_cluster_assign
    import gtca_pkg::*;
#(
    parameter int NUM_TRACKS = 3
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int        NUM_STAGES = 6;
    localparam ent_mask_t ACTIVE     = active_mask(NUM_TRACKS);

    // Stage valids and advance enables; stage k loads when adv[k] is high.
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] adv;

    // Stage payloads.
    item_t                     item_reg;
    absd_t     [NUM_ENT-1:0]   adx_reg;
    absd_t     [NUM_ENT-1:0]   ady_reg;
    absd_t     [NUM_ENT-1:0]   adx_next;
    absd_t     [NUM_ENT-1:0]   ady_next;
    sq_t       [NUM_ENT-1:0]   sqx_reg;
    sq_t       [NUM_ENT-1:0]   sqy_reg;
    sq_t       [NUM_ENT-1:0]   sqx_next;
    sq_t       [NUM_ENT-1:0]   sqy_next;
    dist_t     [NUM_ENT-1:0]   dist_reg;
    dist_t     [NUM_ENT-1:0]   dist_next;
    dist_t     [NUM_ENT-1:0]   dist5_reg;
    ent_mask_t                 win1_reg;
    ent_mask_t                 win1_next;
    result_t                   result_reg;
    result_t                   result_next;

    coord_t    [SLOTS-1:0]     tx;
    coord_t    [SLOTS-1:0]     ty;
    coord_t    [SLOTS-1:0]     cx;
    coord_t    [SLOTS-1:0]     cy;
    ent_mask_t                 mask2;
    ent_mask_t                 win2;
    ent_mask_t                 mask3;
    ent_mask_t                 sel;
    idx_t      [SLOTS-1:0]     assign_idx;

    //--------------------------------------------------------------------
    // Handshake: a stage takes a new beat when it is empty or its
    // successor advances. The output register advances on result_ready.
    //--------------------------------------------------------------------
    always_comb
    begin
        adv[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || result_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next = vld_reg;
        if (adv[0])
        begin
            vld_next[0] = item_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (adv[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    assign item_ready   = adv[0];
    assign result_valid = vld_reg[NUM_STAGES-1];
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    //--------------------------------------------------------------------
    // Stage 2: absolute per-axis differences. The 17-bit difference never
    // reaches -65536, so its magnitude fits 16 bits.
    //--------------------------------------------------------------------
    always_comb
    begin
        logic signed [COORD_W:0] dx;
        logic signed [COORD_W:0] dy;
        tx[0] = item_reg.track0_x;
        ty[0] = item_reg.track0_y;
        tx[1] = item_reg.track1_x;
        ty[1] = item_reg.track1_y;
        tx[2] = item_reg.track2_x;
        ty[2] = item_reg.track2_y;
        cx[0] = item_reg.cluster0_x;
        cy[0] = item_reg.cluster0_y;
        cx[1] = item_reg.cluster1_x;
        cy[1] = item_reg.cluster1_y;
        cx[2] = item_reg.cluster2_x;
        cy[2] = item_reg.cluster2_y;
        for (int k = 0; k < NUM_ENT; k++)
        begin
            dx = {tx[k / SLOTS][COORD_W-1], tx[k / SLOTS]}
               - {cx[k % SLOTS][COORD_W-1], cx[k % SLOTS]};
            dy = {ty[k / SLOTS][COORD_W-1], ty[k / SLOTS]}
               - {cy[k % SLOTS][COORD_W-1], cy[k % SLOTS]};
            adx_next[k] = dx[COORD_W] ? ABS_W'(-dx) : ABS_W'(dx);
            ady_next[k] = dy[COORD_W] ? ABS_W'(-dy) : ABS_W'(dy);
        end
    end

    //--------------------------------------------------------------------
    // Stage 3: squares, one 16x16 multiplier per axis and entry.
    // Stage 4: squared distance, one add per entry.
    //--------------------------------------------------------------------
    always_comb
    begin
        for (int k = 0; k < NUM_ENT; k++)
        begin
            sqx_next[k]  = {{ABS_W{1'b0}}, adx_reg[k]} * {{ABS_W{1'b0}}, adx_reg[k]};
            sqy_next[k]  = {{ABS_W{1'b0}}, ady_reg[k]} * {{ABS_W{1'b0}}, ady_reg[k]};
            dist_next[k] = {1'b0, sqx_reg[k]} + {1'b0, sqy_reg[k]};
        end
    end

    //--------------------------------------------------------------------
    // Stage 5: first round over all active entries.
    //--------------------------------------------------------------------
    assign win1_next = pick_first_min(dist_reg, ACTIVE);

    //--------------------------------------------------------------------
    // Stage 6: second round over what is left, then the last free entry
    // (if any) is the third round. Drop the picks into per-track indices.
    //--------------------------------------------------------------------
    always_comb
    begin
        mask2 = retire(ACTIVE, win1_reg);
        win2  = pick_first_min(dist5_reg, mask2);
        mask3 = retire(mask2, win2);
        sel   = win1_reg | win2 | mask3;
        for (int i = 0; i < SLOTS; i++)
        begin
            assign_idx[i] = '0;
            for (int j = 0; j < SLOTS; j++)
            begin
                if (sel[i * SLOTS + j])
                begin
                    assign_idx[i] = IDX_W'(j);
                end
            end
        end
        result_next.track0_cluster = assign_idx[0];
        result_next.track1_cluster = assign_idx[1];
        result_next.track2_cluster = assign_idx[2];
    end

    //--------------------------------------------------------------------
    // Payload registers: load only when the stage advances on a valid beat.
    //--------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv[0] && item_valid)
        begin
            item_reg <= item;
        end
        if (adv[1] && vld_reg[0])
        begin
            adx_reg <= adx_next;
            ady_reg <= ady_next;
        end
        if (adv[2] && vld_reg[1])
        begin
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
        end
        if (adv[3] && vld_reg[2])
        begin
            dist_reg <= dist_next;
        end
        if (adv[4] && vld_reg[3])
        begin
            dist5_reg <= dist_reg;
            win1_reg  <= win1_next;
        end
        if (adv[5] && vld_reg[4])
        begin
            result_reg <= result_next;
        end
    end

    //--------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------

    // The first pick is exactly one entry.
    a_win1_onehot : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] |-> $onehot(win1_reg))
        else $error("first-round pick is not one-hot");

    // Tracks 0 and 1 never share a cluster, and indices stay within the active set.
    a_distinct : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.track0_cluster != result.track1_cluster)
                      && (result.track0_cluster < IDX_W'(NUM_TRACKS))
                      && (result.track1_cluster < IDX_W'(NUM_TRACKS)))
        else $error("track assignment repeats a cluster or leaves the active set");

    // The input stalls only when every stage is full and the result is held.
    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (&vld_reg) && !result_ready)
        else $error("input stalled while the pipeline has room");

endmodule
